>>> hdl/blale_pkg.sv
// Shared constants, codes and types for the bounded array list engine.
`timescale 1ns / 1ps
`default_nettype none

package blale_pkg;

   localparam int DEPTH       = 16;
   localparam int DATA_BITS   = 32;
   localparam int IDX_BITS    = $clog2(DEPTH);
   localparam int CNT_BITS    = $clog2(DEPTH + 1);
   localparam int TOT_BITS    = DATA_BITS + IDX_BITS;
   localparam int OP_BITS     = 4;
   localparam int INDEX_BITS  = 5;
   localparam int POS_BITS    = 5;
   localparam int COUNT_BITS  = 5;
   localparam int CAP_BITS    = 5;
   localparam int CAP_RESET   = 16;

   typedef enum logic [OP_BITS-1:0] {
      OP_APPEND        = 4'd0,
      OP_INSERT_AT     = 4'd1,
      OP_DELETE_AT     = 4'd2,
      OP_GET           = 4'd3,
      OP_SET           = 4'd4,
      OP_INSERT_SORTED = 4'd5,
      OP_SEARCH        = 4'd6,
      OP_REVERSE       = 4'd7,
      OP_STATS         = 4'd8
   } op_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_KEY,
      CELL_LEFT,
      CELL_RIGHT,
      CELL_MIRROR
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         live;
      logic         capture;
   } cell_ctl_type;

endpackage

`default_nettype wire

>>> hdl/blale_req_if.sv
// Request channel interface: operation transaction into the list engine.
`timescale 1ns / 1ps
`default_nettype none

interface blale_req_if import blale_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [OP_BITS-1:0]          op;
   logic [INDEX_BITS-1:0]       index;
   logic signed [DATA_BITS-1:0] value;

   modport source (output valid, output op, output index, output value, input ready);
   modport sink   (input valid, input op, input index, input value, output ready);
endinterface

`default_nettype wire

>>> hdl/blale_rsp_if.sv
// Response channel interface: result transaction out of the list engine.
`timescale 1ns / 1ps
`default_nettype none

interface blale_rsp_if import blale_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic                        status;
   logic signed [DATA_BITS-1:0] read_value;
   logic signed [POS_BITS-1:0]  position;
   logic [COUNT_BITS-1:0]       count;
   logic signed [DATA_BITS-1:0] minimum;
   logic signed [DATA_BITS-1:0] maximum;
   logic signed [TOT_BITS-1:0]  total;
   logic                        ascending;

   modport source (output valid, output status, output read_value, output position,
                   output count, output minimum, output maximum, output total,
                   output ascending, input ready);
   modport sink   (input valid, input status, input read_value, input position,
                   input count, input minimum, input maximum, input total,
                   input ascending, output ready);
endinterface

`default_nettype wire

>>> hdl/blale_cell.sv
// One list slot: holds an entry, shifts with its neighbors, flags compares.
`timescale 1ns / 1ps
`default_nettype none

module blale_cell import blale_pkg::*; (
   input  wire logic                        clock,
   input  wire cell_ctl_type                ctl,
   input  wire logic signed [DATA_BITS-1:0] key,
   input  wire logic signed [DATA_BITS-1:0] left_data,
   input  wire logic signed [DATA_BITS-1:0] right_data,
   input  wire logic signed [DATA_BITS-1:0] mirror_data,
   input  wire logic                        run_in,
   output      logic signed [DATA_BITS-1:0] entry,
   output      logic                        run_out,
   output      logic                        match
);

   logic signed [DATA_BITS-1:0] entry_ff, entry_in;
   logic                        gt_ff, gt_in;
   logic                        eq_ff, eq_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.cmd)
         CELL_HOLD:   entry_in = entry_ff;
         CELL_KEY:    entry_in = key;
         CELL_LEFT:   entry_in = left_data;
         CELL_RIGHT:  entry_in = right_data;
         CELL_MIRROR: entry_in = mirror_data;
         default:     entry_in = entry_ff;
      endcase
   end

   // compare flags latched when the transaction is taken
   always_comb begin
      gt_in = gt_ff;
      eq_in = eq_ff;
      if (ctl.capture) begin
         gt_in = entry_ff > key;
         eq_in = entry_ff == key;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      gt_ff    <= gt_in;
      eq_ff    <= eq_in;
   end

   // run: every live slot from here upward is greater than the key
   assign run_out = run_in & (~ctl.live | gt_ff);
   assign match   = ctl.live & eq_ff;
   assign entry   = entry_ff;

endmodule

`default_nettype wire

>>> hdl/bounded_array_list_engine_unit.sv
// Top level of the bounded array list engine: control sequencer and cell row.
//
// Usage:
//   req_if carries one operation per transaction (op, index, value); rsp_if
//   returns exactly one result transaction per request, in order. Both use
//   valid/ready; a transaction moves at a clock edge where both are high.
//   csr_write_enable with csr_write_data sets the capacity register; write it
//   only while no request is outstanding.
// Timing:
//   A request is taken in ST_IDLE. In ST_EXEC the cell row is updated and the
//   result is registered at the same clock edge. Stats then walks the row as a
//   ring in ST_STATS, one entry a cycle, before its result is registered. One
//   request is handled at a time.
// Reset:
//   Synchronous, active high. The list becomes empty and capacity returns to
//   16; entry contents are not cleared and are never read before written.
// Back-pressure:
//   The result stays in its output register until taken. A new request is
//   accepted in the cycle the pending result leaves.
`timescale 1ns / 1ps
`default_nettype none

module bounded_array_list_engine_unit import blale_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [CAP_BITS-1:0] csr_write_data,
   blale_req_if.sink                req_if,
   blale_rsp_if.source              rsp_if
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EXEC  = 3'b010,
      ST_STATS = 3'b100
   } state_type;

   state_type                   state_ff, state_in;
   logic [CAP_BITS-1:0]         capacity_ff, capacity_in;
   logic [CNT_BITS-1:0]         used_ff, used_in;
   logic [OP_BITS-1:0]          op_ff;
   logic [INDEX_BITS-1:0]       idx_ff;
   logic signed [DATA_BITS-1:0] key_ff;
   logic [IDX_BITS-1:0]         step_ff, step_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        status_ff, status_in;
   logic signed [DATA_BITS-1:0] read_ff, read_in;
   logic signed [POS_BITS-1:0]  pos_ff, pos_in;
   logic [COUNT_BITS-1:0]       count_ff, count_in;
   logic signed [DATA_BITS-1:0] min_ff, min_in;
   logic signed [DATA_BITS-1:0] max_ff, max_in;
   logic signed [TOT_BITS-1:0]  tot_ff, tot_in;
   logic                        asc_ff, asc_in;

   cell_ctl_type                ctl [DEPTH];
   logic signed [DATA_BITS-1:0] entry_w [DEPTH];
   logic signed [DATA_BITS-1:0] mirror_w [DEPTH];
   logic [DEPTH-1:0]            match_w;
   logic [DEPTH:0]              run_w;
   logic [DEPTH-1:0]            shift_w;
   logic signed [DATA_BITS-1:0] cell_key;
   logic signed [DATA_BITS-1:0] sel_entry;
   logic signed [DATA_BITS-1:0] head;
   logic signed [DATA_BITS-1:0] nxt;
   logic                        req_fire;
   logic                        full;
   logic                        idx_ok;
   logic                        idx_ok_ins;

   assign req_if.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign req_fire     = req_if.valid && req_if.ready;

   assign cell_key   = (state_ff == ST_IDLE) ? req_if.value : key_ff;
   assign run_w[DEPTH] = 1'b1;
   assign shift_w    = {run_w[DEPTH-2:0], 1'b0};
   assign sel_entry  = entry_w[IDX_BITS'(idx_ff)];
   assign head       = entry_w[0];
   assign nxt        = entry_w[1];

   assign full       = (int'(used_ff) >= int'(capacity_ff)) || (int'(used_ff) >= DEPTH);
   assign idx_ok     = int'(idx_ff) < int'(used_ff);
   assign idx_ok_ins = int'(idx_ff) <= int'(used_ff);

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [CNT_BITS-1:0] mirror_at;
      assign mirror_at   = used_ff - CNT_BITS'(1) - CNT_BITS'(g);
      assign mirror_w[g] = entry_w[IDX_BITS'(mirror_at)];

      blale_cell u_cell (
         .clock       (clock),
         .ctl         (ctl[g]),
         .key         (cell_key),
         .left_data   ((g == 0) ? cell_key : entry_w[(g + DEPTH - 1) % DEPTH]),
         .right_data  (entry_w[(g + 1) % DEPTH]),
         .mirror_data (mirror_w[g]),
         .run_in      (run_w[g+1]),
         .entry       (entry_w[g]),
         .run_out     (run_w[g]),
         .match       (match_w[g])
      );
   end

   always_comb begin
      state_in     = state_ff;
      capacity_in  = csr_write_enable ? csr_write_data : capacity_ff;
      used_in      = used_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      status_in    = status_ff;
      read_in      = read_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      tot_in       = tot_ff;
      asc_in       = asc_ff;
      for (int i = 0; i < DEPTH; i++) begin
         ctl[i].cmd     = CELL_HOLD;
         ctl[i].live    = i < int'(used_ff);
         ctl[i].capture = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
               for (int i = 0; i < DEPTH; i++) begin
                  ctl[i].capture = 1'b1;
               end
            end
         end

         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            status_in    = 1'b0;
            read_in      = '0;
            pos_in       = '0;
            min_in       = '0;
            max_in       = '0;
            tot_in       = '0;
            asc_in       = 1'b0;
            unique case (op_type'(op_ff))
               OP_APPEND: begin
                  if (full) begin
                     status_in = 1'b1;
                  end else begin
                     for (int i = 0; i < DEPTH; i++) begin
                        if (i == int'(used_ff)) ctl[i].cmd = CELL_KEY;
                     end
                     used_in = used_ff + CNT_BITS'(1);
                  end
               end
               OP_INSERT_AT: begin
                  if (full || !idx_ok_ins) begin
                     status_in = 1'b1;
                  end else begin
                     for (int i = 0; i < DEPTH; i++) begin
                        if (i == int'(idx_ff)) begin
                           ctl[i].cmd = CELL_KEY;
                        end else if (i > int'(idx_ff) && i <= int'(used_ff)) begin
                           ctl[i].cmd = CELL_LEFT;
                        end
                     end
                     used_in = used_ff + CNT_BITS'(1);
                  end
               end
               OP_DELETE_AT: begin
                  if (!idx_ok) begin
                     status_in = 1'b1;
                  end else begin
                     read_in = sel_entry;
                     for (int i = 0; i < DEPTH; i++) begin
                        if (i >= int'(idx_ff) && i + 1 < int'(used_ff)) begin
                           ctl[i].cmd = CELL_RIGHT;
                        end
                     end
                     used_in = used_ff - CNT_BITS'(1);
                  end
               end
               OP_GET: begin
                  if (!idx_ok) begin
                     status_in = 1'b1;
                     read_in   = '1;
                  end else begin
                     read_in = sel_entry;
                  end
               end
               OP_SET: begin
                  if (!idx_ok) begin
                     status_in = 1'b1;
                  end else begin
                     for (int i = 0; i < DEPTH; i++) begin
                        if (i == int'(idx_ff)) ctl[i].cmd = CELL_KEY;
                     end
                  end
               end
               OP_INSERT_SORTED: begin
                  if (full) begin
                     status_in = 1'b1;
                  end else begin
                     for (int i = 0; i < DEPTH; i++) begin
                        if (i <= int'(used_ff)) begin
                           if (shift_w[i]) begin
                              ctl[i].cmd = CELL_LEFT;
                           end else if (run_w[i]) begin
                              ctl[i].cmd = CELL_KEY;
                           end
                        end
                     end
                     used_in = used_ff + CNT_BITS'(1);
                  end
               end
               OP_SEARCH: begin
                  pos_in = '1;
                  for (int i = DEPTH - 1; i >= 0; i--) begin
                     if (match_w[i]) pos_in = POS_BITS'(i);
                  end
               end
               OP_REVERSE: begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (i < int'(used_ff)) ctl[i].cmd = CELL_MIRROR;
                  end
               end
               OP_STATS: begin
                  state_in     = ST_STATS;
                  rsp_valid_in = 1'b0;
                  step_in      = '0;
                  asc_in       = 1'b1;
               end
               default: status_in = 1'b1;
            endcase
            count_in = COUNT_BITS'(used_in);
         end

         ST_STATS: begin
            // rotate the row as a ring; slot 0 sees each entry once
            for (int i = 0; i < DEPTH; i++) begin
               ctl[i].cmd = CELL_RIGHT;
            end
            if (int'(step_ff) < int'(used_ff)) begin
               if (step_ff == '0) begin
                  min_in = head;
                  max_in = head;
               end else begin
                  if (head < min_ff) min_in = head;
                  if (head > max_ff) max_in = head;
               end
               tot_in = tot_ff + {{(TOT_BITS-DATA_BITS){head[DATA_BITS-1]}}, head};
            end
            if (int'(step_ff) + 1 < int'(used_ff) && head > nxt) asc_in = 1'b0;
            step_in = step_ff + IDX_BITS'(1);
            if (int'(step_ff) == DEPTH - 1) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = 1'b0;
               read_in      = '0;
               pos_in       = '0;
               count_in     = COUNT_BITS'(used_ff);
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= CAP_BITS'(CAP_RESET);
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_if.op;
         idx_ff <= req_if.index;
         key_ff <= req_if.value;
      end
      step_ff   <= step_in;
      status_ff <= status_in;
      read_ff   <= read_in;
      pos_ff    <= pos_in;
      count_ff  <= count_in;
      min_ff    <= min_in;
      max_ff    <= max_in;
      tot_ff    <= tot_in;
      asc_ff    <= asc_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = status_ff;
   assign rsp_if.read_value = read_ff;
   assign rsp_if.position   = pos_ff;
   assign rsp_if.count      = count_ff;
   assign rsp_if.minimum    = min_ff;
   assign rsp_if.maximum    = max_ff;
   assign rsp_if.total      = tot_ff;
   assign rsp_if.ascending  = asc_ff;

   a_fire_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_EXEC)
      else $error("accepted request did not start execution");

   a_count_tracks_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> int'(count_ff) == int'(used_ff))
      else $error("pending result count differs from list length");

   a_used_only_in_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_EXEC |=> $stable(used_ff))
      else $error("list length changed outside execution");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EXEC || $past(state_ff) == ST_STATS))
      else $error("result raised without an operation");

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STATS |-> int'(used_ff) <= DEPTH && !req_if.ready)
      else $error("stats walk overlapped with a new request or bad length");

endmodule

`default_nettype wire
